// ===== sv/three_band_envelope_analyzer_macros.svh =====
// Assertion macros shared by the analyzer RTL.
// Every property is sampled on clk_i and disabled while rst_ni is low.
`ifndef THREE_BAND_ENVELOPE_ANALYZER_MACROS_SVH
`define THREE_BAND_ENVELOPE_ANALYZER_MACROS_SVH
`ifndef SYNTHESIS
`define TBEA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TBEA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TBEA_ASSERT(name, prop, msg)
`define TBEA_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// ===== sv/tbea_pkg.sv =====
package tbea_pkg;

  // Fixed-point layout.
  localparam int COEF_FRAC_BITS  = 24;
  localparam int STATE_FRAC_BITS = 24;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int FMT_W    = 2;
  localparam int COEF_W   = COEF_FRAC_BITS + 1;
  localparam int X_W      = STATE_FRAC_BITS + 1;
  localparam int LP_W     = STATE_FRAC_BITS + 4;
  localparam int ENV_W    = STATE_FRAC_BITS + 3;
  localparam int RECT_W   = LP_W + 1;
  localparam int GAP_W    = LP_W + 2;
  localparam int MUL_A_W  = LP_W + 3;
  localparam int MUL_B_W  = COEF_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W + 1;
  localparam int SUM_W    = MUL_A_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_BASS_COEF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FMT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BASS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MID     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEVEL   = 3'd7;

  // Sample format bits: 16-bit signed samples and stereo frames.
  localparam logic [FMT_W-1:0] FMT_WIDE   = 2'b01;
  localparam logic [FMT_W-1:0] FMT_STEREO = 2'b10;

  localparam logic [COEF_W-1:0] RST_BASS_COEF    = 25'd358552;
  localparam logic [COEF_W-1:0] RST_HIGH_COEF    = 25'd7171047;
  localparam logic [COEF_W-1:0] RST_RELEASE_COEF = 25'd2013;
  localparam logic [FMT_W-1:0]  RST_SAMPLE_FMT   = 2'd3;
  localparam logic [GAIN_W-1:0] RST_GAIN_BASS    = 16'd12288;
  localparam logic [GAIN_W-1:0] RST_GAIN_MID     = 16'd12288;
  localparam logic [GAIN_W-1:0] RST_GAIN_HIGH    = 16'd28672;
  localparam logic [GAIN_W-1:0] RST_GAIN_LEVEL   = 16'd10240;

  // Request to the shared multiplier.
  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

// ===== sv/tbea_mul.sv =====
// Shared signed-by-unsigned multiplier with a registered product.
module tbea_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tbea_pkg::mul_req_t                  req_i,
  output logic signed [tbea_pkg::PROD_W-1:0]  prod_o
);

  logic signed [tbea_pkg::PROD_W-1:0] prod_q;

  // The product register only loads when a request is issued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (req_i.en) begin
      prod_q <= $signed(req_i.a) * $signed({1'b0, req_i.b});
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/three_band_envelope_analyzer.sv =====
// A frame without block_end runs the low-pass and envelope steps and returns to idle with
// no result; a frame with block_end also runs the gain steps and then waits until the output
// register is free. A new frame is taken only in idle, since every filter, envelope and gain
// product goes through the single shared multiplier.
// Reset: configuration registers return to their defaults; filter and envelope state clear.
module three_band_envelope_analyzer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbea_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tbea_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Frame requests.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tbea_pkg::SAMPLE_W-1:0]     first_sample_i,
  input  logic [tbea_pkg::SAMPLE_W-1:0]     second_sample_i,
  input  logic                              block_end_i,
  // Level results.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tbea_pkg::LEVEL_W-1:0]      bass_level_o,
  output logic [tbea_pkg::LEVEL_W-1:0]      mid_level_o,
  output logic [tbea_pkg::LEVEL_W-1:0]      high_level_o,
  output logic [tbea_pkg::LEVEL_W-1:0]      overall_level_o
);

`include "three_band_envelope_analyzer_macros.svh"

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] ST_LP_BASS  = 4'd1;
  localparam logic [ST_W-1:0] ST_LP_UPPER = 4'd2;
  localparam logic [ST_W-1:0] ST_ENV_BASS = 4'd3;
  localparam logic [ST_W-1:0] ST_ENV_MID  = 4'd4;
  localparam logic [ST_W-1:0] ST_ENV_HIGH = 4'd5;
  localparam logic [ST_W-1:0] ST_ENV_ALL  = 4'd6;
  localparam logic [ST_W-1:0] ST_ENV_DONE = 4'd7;
  localparam logic [ST_W-1:0] ST_OUT_MID  = 4'd8;
  localparam logic [ST_W-1:0] ST_OUT_HIGH = 4'd9;
  localparam logic [ST_W-1:0] ST_OUT_ALL  = 4'd10;
  localparam logic [ST_W-1:0] ST_OUT_DONE = 4'd11;

  localparam int X_W    = tbea_pkg::X_W;
  localparam int LP_W   = tbea_pkg::LP_W;
  localparam int ENV_W  = tbea_pkg::ENV_W;
  localparam int RECT_W = tbea_pkg::RECT_W;
  localparam int GAP_W  = tbea_pkg::GAP_W;
  localparam int A_W    = tbea_pkg::MUL_A_W;
  localparam int B_W    = tbea_pkg::MUL_B_W;
  localparam int SUM_W  = tbea_pkg::SUM_W;
  localparam int LVL_W  = tbea_pkg::LEVEL_W;
  localparam int SFB    = tbea_pkg::STATE_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] LP_MAX  = SUM_W'((64'sd1 <<< (LP_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] LP_MIN  = SUM_W'(-(64'sd1 <<< (LP_W - 1)));
  localparam logic signed [SUM_W-1:0] ENV_MAX = SUM_W'((64'sd1 <<< ENV_W) - 64'sd1);

  // Magnitude of a signed value, returned unsigned.
  function automatic logic [RECT_W-1:0] mag_f(input logic signed [RECT_W-1:0] v);
    logic [RECT_W-1:0] r;
    r = v[RECT_W-1] ? RECT_W'(-v) : RECT_W'(v);
    return r;
  endfunction

  // Configuration registers.
  logic [tbea_pkg::COEF_W-1:0] bass_coef_q, high_coef_q, release_coef_q;
  logic [tbea_pkg::FMT_W-1:0]  sample_fmt_q;
  logic [tbea_pkg::GAIN_W-1:0] gain_bass_q, gain_mid_q, gain_high_q, gain_level_q;

  // Sequencer and working state.
  logic [ST_W-1:0]         state_q, state_d;
  logic                    last_q;
  logic signed [X_W-1:0]   x_q, x_d;
  logic signed [LP_W-1:0]  bass_lp_q, bass_lp_d, upper_lp_q, upper_lp_d;
  logic [ENV_W-1:0]        env_bass_q, env_bass_d, env_mid_q, env_mid_d;
  logic [ENV_W-1:0]        env_high_q, env_high_d, env_all_q, env_all_d;
  logic signed [GAP_W-1:0] gap_q, gap_d;
  logic                    attack_q, attack_d;
  logic [LVL_W-1:0]        lvl_bass_q, lvl_bass_d, lvl_mid_q, lvl_mid_d;
  logic [LVL_W-1:0]        lvl_high_q, lvl_high_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [LVL_W-1:0] out_bass_q, out_bass_d, out_mid_q, out_mid_d;
  logic [LVL_W-1:0] out_high_q, out_high_d, out_all_q, out_all_d;

  // Shared multiplier.
  tbea_pkg::mul_req_t                     mul_req;
  logic signed [tbea_pkg::PROD_W-1:0]     mul_prod;
  logic signed [tbea_pkg::PROD_W-1:0]     prod_coef_sh, prod_gain_sh;

  // Combinational helpers.
  logic signed [16:0]       sum_wide;
  logic signed [8:0]        sum_narrow;
  logic signed [RECT_W-1:0] band_val;
  logic [ENV_W-1:0]         env_sel;
  logic [ENV_W-1:0]         env_upd;
  logic [ENV_W-1:0]         env_apply_sel;
  logic signed [SUM_W-1:0]  env_sum, env_inc, lp_sum;
  logic signed [LP_W-1:0]   lp_apply_sel, lp_upd;
  logic signed [X_W-1:0]    lp_in_sel;
  logic [LVL_W-1:0]         lvl_sat;
  logic                     load_out;

  tbea_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bass_coef_q    <= tbea_pkg::RST_BASS_COEF;
      high_coef_q    <= tbea_pkg::RST_HIGH_COEF;
      release_coef_q <= tbea_pkg::RST_RELEASE_COEF;
      sample_fmt_q   <= tbea_pkg::RST_SAMPLE_FMT;
      gain_bass_q    <= tbea_pkg::RST_GAIN_BASS;
      gain_mid_q     <= tbea_pkg::RST_GAIN_MID;
      gain_high_q    <= tbea_pkg::RST_GAIN_HIGH;
      gain_level_q   <= tbea_pkg::RST_GAIN_LEVEL;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tbea_pkg::REG_BASS_COEF:    bass_coef_q    <= cfg_data_i;
        tbea_pkg::REG_HIGH_COEF:    high_coef_q    <= cfg_data_i;
        tbea_pkg::REG_RELEASE_COEF: release_coef_q <= cfg_data_i;
        tbea_pkg::REG_SAMPLE_FMT:   sample_fmt_q   <= cfg_data_i[tbea_pkg::FMT_W-1:0];
        tbea_pkg::REG_GAIN_BASS:    gain_bass_q    <= cfg_data_i[tbea_pkg::GAIN_W-1:0];
        tbea_pkg::REG_GAIN_MID:     gain_mid_q     <= cfg_data_i[tbea_pkg::GAIN_W-1:0];
        tbea_pkg::REG_GAIN_HIGH:    gain_high_q    <= cfg_data_i[tbea_pkg::GAIN_W-1:0];
        tbea_pkg::REG_GAIN_LEVEL:   gain_level_q   <= cfg_data_i[tbea_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Fold the frame to a mono fixed-point sample. In 8-bit mode flipping the top bit
  // of the byte removes the offset of 128.
  always_comb begin
    sum_wide   = $signed({first_sample_i[15], first_sample_i})
               + $signed({second_sample_i[15], second_sample_i});
    sum_narrow = $signed({~first_sample_i[7], ~first_sample_i[7], first_sample_i[6:0]})
               + $signed({~second_sample_i[7], ~second_sample_i[7], second_sample_i[6:0]});
    case (sample_fmt_q)
      tbea_pkg::FMT_WIDE | tbea_pkg::FMT_STEREO:
        x_d = $signed({sum_wide, {(SFB - 16){1'b0}}});
      tbea_pkg::FMT_WIDE:   x_d = $signed({first_sample_i, {(SFB - 15){1'b0}}});
      tbea_pkg::FMT_STEREO: x_d = $signed({sum_narrow, {(SFB - 8){1'b0}}});
      default: x_d = $signed({~first_sample_i[7], first_sample_i[6:0], {(SFB - 7){1'b0}}});
    endcase
  end

  // Scaled products: coefficient products and gain products each drop their fraction.
  assign prod_coef_sh = mul_prod >>> tbea_pkg::COEF_FRAC_BITS;
  assign prod_gain_sh = mul_prod >>> tbea_pkg::STATE_FRAC_BITS;

  // Low-pass update: state plus the registered coefficient product, saturated.
  always_comb begin
    lp_apply_sel = (state_q == ST_LP_UPPER) ? bass_lp_q : upper_lp_q;
    lp_sum = SUM_W'(lp_apply_sel) + prod_coef_sh[SUM_W-1:0];
    if (lp_sum > LP_MAX) begin
      lp_upd = LP_MAX[LP_W-1:0];
    end else if (lp_sum < LP_MIN) begin
      lp_upd = LP_MIN[LP_W-1:0];
    end else begin
      lp_upd = lp_sum[LP_W-1:0];
    end
  end

  // Envelope update: attack takes half the gap, release takes the registered product.
  always_comb begin
    case (state_q)
      ST_ENV_MID:  env_apply_sel = env_bass_q;
      ST_ENV_HIGH: env_apply_sel = env_mid_q;
      ST_ENV_ALL:  env_apply_sel = env_high_q;
      default:     env_apply_sel = env_all_q;
    endcase
    env_inc = attack_q ? SUM_W'(gap_q >>> 1) : prod_coef_sh[SUM_W-1:0];
    env_sum = $signed({{(SUM_W - ENV_W){1'b0}}, env_apply_sel}) + env_inc;
    if (env_sum < 0) begin
      env_upd = '0;
    end else if (env_sum > ENV_MAX) begin
      env_upd = ENV_MAX[ENV_W-1:0];
    end else begin
      env_upd = env_sum[ENV_W-1:0];
    end
  end

  // Band value and envelope for the follower being issued.
  always_comb begin
    case (state_q)
      ST_ENV_BASS: begin
        band_val = RECT_W'(bass_lp_q);
        env_sel  = env_bass_q;
      end
      ST_ENV_MID: begin
        band_val = RECT_W'(upper_lp_q) - RECT_W'(bass_lp_q);
        env_sel  = env_mid_q;
      end
      ST_ENV_HIGH: begin
        band_val = RECT_W'(x_q) - RECT_W'(upper_lp_q);
        env_sel  = env_high_q;
      end
      default: begin
        band_val = RECT_W'(x_q);
        env_sel  = env_all_q;
      end
    endcase
    gap_d    = $signed({1'b0, mag_f(band_val)}) - $signed({{(GAP_W - ENV_W){1'b0}}, env_sel});
    attack_d = !gap_d[GAP_W-1] && (gap_d != '0);
  end

  // Gain product saturated to the level width.
  assign lvl_sat = (prod_gain_sh[tbea_pkg::PROD_W-1:LVL_W] != '0) ? '1
                                                                  : prod_gain_sh[LVL_W-1:0];

  assign load_out = (state_q == ST_OUT_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer: each working state applies the previous product, issues the next one, or both.
  always_comb begin
    state_d    = state_q;
    bass_lp_d  = bass_lp_q;
    upper_lp_d = upper_lp_q;
    env_bass_d = env_bass_q;
    env_mid_d  = env_mid_q;
    env_high_d = env_high_q;
    env_all_d  = env_all_q;
    lvl_bass_d = lvl_bass_q;
    lvl_mid_d  = lvl_mid_q;
    lvl_high_d = lvl_high_q;
    lp_in_sel  = x_q;
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LP_BASS;
        end
      end
      ST_LP_BASS: begin
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(lp_in_sel) - A_W'(bass_lp_q);
        mul_req.b  = bass_coef_q;
        state_d    = ST_LP_UPPER;
      end
      ST_LP_UPPER: begin
        bass_lp_d  = lp_upd;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(lp_in_sel) - A_W'(upper_lp_q);
        mul_req.b  = high_coef_q;
        state_d    = ST_ENV_BASS;
      end
      ST_ENV_BASS: begin
        upper_lp_d = lp_upd;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(gap_d);
        mul_req.b  = release_coef_q;
        state_d    = ST_ENV_MID;
      end
      ST_ENV_MID: begin
        env_bass_d = env_upd;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(gap_d);
        mul_req.b  = release_coef_q;
        state_d    = ST_ENV_HIGH;
      end
      ST_ENV_HIGH: begin
        env_mid_d  = env_upd;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(gap_d);
        mul_req.b  = release_coef_q;
        state_d    = ST_ENV_ALL;
      end
      ST_ENV_ALL: begin
        env_high_d = env_upd;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(gap_d);
        mul_req.b  = release_coef_q;
        state_d    = ST_ENV_DONE;
      end
      ST_ENV_DONE: begin
        env_all_d = env_upd;
        if (last_q) begin
          mul_req.en = 1'b1;
          mul_req.a  = A_W'(env_bass_q);
          mul_req.b  = B_W'(gain_bass_q);
          state_d    = ST_OUT_MID;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT_MID: begin
        lvl_bass_d = lvl_sat;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(env_mid_q);
        mul_req.b  = B_W'(gain_mid_q);
        state_d    = ST_OUT_HIGH;
      end
      ST_OUT_HIGH: begin
        lvl_mid_d  = lvl_sat;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(env_high_q);
        mul_req.b  = B_W'(gain_high_q);
        state_d    = ST_OUT_ALL;
      end
      ST_OUT_ALL: begin
        lvl_high_d = lvl_sat;
        mul_req.en = 1'b1;
        mul_req.a  = A_W'(env_all_q);
        mul_req.b  = B_W'(gain_level_q);
        state_d    = ST_OUT_DONE;
      end
      ST_OUT_DONE: begin
        // Wait here until the output register is free.
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register loads the finished levels and holds them until taken.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_bass_d  = out_bass_q;
    out_mid_d   = out_mid_q;
    out_high_d  = out_high_q;
    out_all_d   = out_all_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_bass_d  = lvl_bass_q;
      out_mid_d   = lvl_mid_q;
      out_high_d  = lvl_high_q;
      out_all_d   = lvl_sat;
    end
  end

  // Control and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bass_lp_q   <= '0;
      upper_lp_q  <= '0;
      env_bass_q  <= '0;
      env_mid_q   <= '0;
      env_high_q  <= '0;
      env_all_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bass_lp_q   <= bass_lp_d;
      upper_lp_q  <= upper_lp_d;
      env_bass_q  <= env_bass_d;
      env_mid_q   <= env_mid_d;
      env_high_q  <= env_high_d;
      env_all_q   <= env_all_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q    <= x_d;
      last_q <= block_end_i;
    end
    gap_q      <= gap_d;
    attack_q   <= attack_d;
    lvl_bass_q <= lvl_bass_d;
    lvl_mid_q  <= lvl_mid_d;
    lvl_high_q <= lvl_high_d;
    out_bass_q <= out_bass_d;
    out_mid_q  <= out_mid_d;
    out_high_q <= out_high_d;
    out_all_q  <= out_all_d;
  end

  assign out_valid_o     = out_valid_q;
  assign bass_level_o    = out_bass_q;
  assign mid_level_o     = out_mid_q;
  assign high_level_o    = out_high_q;
  assign overall_level_o = out_all_q;

  // An accepted frame always starts with the bass low-pass product.
  `TBEA_ASSERT_NEXT(a_start_seq, in_valid_i && in_ready_o, state_q == ST_LP_BASS, "no start")
  // A frame without block end returns to idle right after the last envelope.
  `TBEA_ASSERT_NEXT(a_no_result, (state_q == ST_ENV_DONE) && !last_q, state_q == ST_IDLE, "end")
  // A new result only appears from the final output step.
  `TBEA_ASSERT(a_out_src, $rose(out_valid_o) |-> $past(state_q) == ST_OUT_DONE, "stray result")
  // The bass filter state only moves in its own update step.
  `TBEA_ASSERT_NEXT(a_bass_hold, state_q != ST_LP_UPPER, $stable(bass_lp_q), "bass state moved")

endmodule

// ===== tb/three_band_envelope_analyzer_tb.sv =====
module three_band_envelope_analyzer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W        = tbea_pkg::SAMPLE_W;
  localparam int LEVEL_W         = tbea_pkg::LEVEL_W;
  localparam int GAIN_W          = tbea_pkg::GAIN_W;
  localparam int FMT_W           = tbea_pkg::FMT_W;
  localparam int CFG_IDX_W       = tbea_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = tbea_pkg::CFG_DATA_W;
  localparam int LP_W            = tbea_pkg::LP_W;
  localparam int ENV_W           = tbea_pkg::ENV_W;
  localparam int STATE_FRAC_BITS = tbea_pkg::STATE_FRAC_BITS;
  localparam int COEF_FRAC_BITS  = tbea_pkg::COEF_FRAC_BITS;

  localparam int NUM_REGS        = 8;
  localparam int SETTLE_CYCLES   = 12;
  localparam int TAIL_CYCLES     = 20;
  localparam int BACKPRESSURE_LEN = 300;
  localparam int QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] first_s;
    logic [SAMPLE_W-1:0] second_s;
    logic                blk_end;
  } frame_t;

  // Index 0 is bass, then mid, high and overall.
  typedef logic [3:0][LEVEL_W-1:0] level_vec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   first_sample_i = '0;
  logic [SAMPLE_W-1:0]   second_sample_i = '0;
  logic                  block_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [LEVEL_W-1:0]    bass_level_o;
  logic [LEVEL_W-1:0]    mid_level_o;
  logic [LEVEL_W-1:0]    high_level_o;
  logic [LEVEL_W-1:0]    overall_level_o;

  three_band_envelope_analyzer u_top (.*);

  always #5 clk_i = ~clk_i;

  // Stimulus and expectation stores.
  frame_t     frames_pending [$];
  level_vec_t levels_due [$];
  logic       frame_taken = 1'b0;

  // Shadow of the register file and the filter and envelope state.
  logic [CFG_DATA_W-1:0] shadow_regs [NUM_REGS];
  longint lp_bass = 0;
  longint lp_upper = 0;
  longint envelope [4] = '{0, 0, 0, 0};

  int send_skip_pct = 37;
  int take_skip_pct = 37;
  logic backpressure_on = 1'b0;
  int backpressure_cycles = 0;

  int fail_count = 0;
  int frames_accepted = 0;
  int results_checked = 0;
  int settings_count = 1;
  int quiet_cycles = 0;

  string level_name [4] = '{"bass_level", "mid_level", "high_level", "overall_level"};

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint clip_lowpass(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (LP_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Advance the band split and envelopes by one frame and queue the levels
  // that a block end makes visible.
  function automatic void analyze_frame(input frame_t f);
    logic [FMT_W-1:0] fmt;
    longint a, b, x, gap, e, prod, env_max;
    longint rect [4];
    level_vec_t lv;
    fmt = shadow_regs[tbea_pkg::REG_SAMPLE_FMT][FMT_W-1:0];
    env_max = (longint'(1) <<< ENV_W) - 1;

    // Fold the frame to a mono value with STATE_FRAC_BITS fraction bits.
    if ((fmt & tbea_pkg::FMT_WIDE) != 0) begin
      a = longint'($signed(f.first_s));
      b = longint'($signed(f.second_s));
      if ((fmt & tbea_pkg::FMT_STEREO) != 0)
        x = (a + b) * (longint'(1) <<< (STATE_FRAC_BITS - 16));
      else x = a * (longint'(1) <<< (STATE_FRAC_BITS - 15));
    end else begin
      a = longint'(f.first_s[7:0]) - 128;
      b = longint'(f.second_s[7:0]) - 128;
      if ((fmt & tbea_pkg::FMT_STEREO) != 0)
        x = (a + b) * (longint'(1) <<< (STATE_FRAC_BITS - 8));
      else x = a * (longint'(1) <<< (STATE_FRAC_BITS - 7));
    end

    // Two one-pole low-pass filters; arithmetic shifts floor toward minus infinity.
    lp_bass = clip_lowpass(lp_bass +
      ((longint'(shadow_regs[tbea_pkg::REG_BASS_COEF]) * (x - lp_bass)) >>> COEF_FRAC_BITS));
    lp_upper = clip_lowpass(lp_upper +
      ((longint'(shadow_regs[tbea_pkg::REG_HIGH_COEF]) * (x - lp_upper)) >>> COEF_FRAC_BITS));

    rect[0] = magnitude(lp_bass);
    rect[1] = magnitude(lp_upper - lp_bass);
    rect[2] = magnitude(x - lp_upper);
    rect[3] = magnitude(x);

    // Envelopes rise by half the gap and fall at the release rate.
    for (int i = 0; i < 4; i++) begin
      gap = rect[i] - envelope[i];
      if (rect[i] > envelope[i]) e = envelope[i] + (gap >>> 1);
      else e = envelope[i] +
        ((longint'(shadow_regs[tbea_pkg::REG_RELEASE_COEF]) * gap) >>> COEF_FRAC_BITS);
      if (e < 0) e = 0;
      if (e > env_max) e = env_max;
      envelope[i] = e;
    end

    if (f.blk_end) begin
      for (int i = 0; i < 4; i++) begin
        prod = (envelope[i] * longint'(shadow_regs[tbea_pkg::REG_GAIN_BASS + i]))
               >>> STATE_FRAC_BITS;
        lv[i] = (prod > 65535) ? 16'hFFFF : LEVEL_W'(prod);
      end
      levels_due.push_back(lv);
    end
  endfunction

  // Accepted requests: register writes, frames and level results.
  always @(posedge clk_i) begin : check_levels
    level_vec_t got;
    level_vec_t want;
    frame_t f;
    frame_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tbea_pkg::REG_BASS_COEF, tbea_pkg::REG_HIGH_COEF, tbea_pkg::REG_RELEASE_COEF: begin
            shadow_regs[cfg_index_i] = cfg_data_i;
          end
          tbea_pkg::REG_SAMPLE_FMT: begin
            shadow_regs[cfg_index_i] = CFG_DATA_W'(cfg_data_i[FMT_W-1:0]);
          end
          default: shadow_regs[cfg_index_i] = CFG_DATA_W'(cfg_data_i[GAIN_W-1:0]);
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        f.first_s = first_sample_i;
        f.second_s = second_sample_i;
        f.blk_end = block_end_i;
        analyze_frame(f);
        frames_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        got = {overall_level_o, high_level_o, mid_level_o, bass_level_o};
        if (levels_due.size() == 0) begin
          $display("%0t: unexpected level result, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = levels_due.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t: %s expected %0d got %0d", $time, level_name[i], want[i], got[i]);
              fail_count++;
            end
          end
          results_checked++;
        end
      end
    end
  end

  // Frame driver: holds a request until it is taken, then loads the next one.
  always @(negedge clk_i) begin : drive_frames
    frame_t f;
    if (!in_valid_i || frame_taken) begin
      if (frames_pending.size() > 0 && $urandom_range(99) >= send_skip_pct) begin
        f = frames_pending.pop_front();
        in_valid_i <= 1'b1;
        first_sample_i <= f.first_s;
        second_sample_i <= f.second_s;
        block_end_i <= f.blk_end;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and one long hold-off.
  always @(negedge clk_i) begin
    if (backpressure_on && backpressure_cycles < BACKPRESSURE_LEN) begin
      out_ready_i <= 1'b0;
      backpressure_cycles <= backpressure_cycles + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= take_skip_pct);
    end
  end

  // Watchdog on cycles in which no request of any kind is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_frame(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
                             input logic blk_end);
    frame_t f;
    f.first_s = s0;
    f.second_s = s1;
    f.blk_end = blk_end;
    frames_pending.push_back(f);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return {8'($urandom), 8'hFF};
      3: return {8'($urandom), 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly blocks of frames closed by a block end, with some stray frames.
  task automatic queue_random_blocks(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        queue_frame(pick_sample(), pick_sample(), 1'($urandom_range(1)));
        n++;
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) queue_frame(pick_sample(), pick_sample(), k == len - 1);
        n += len;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] bass,
                                input logic [CFG_DATA_W-1:0] high,
                                input logic [CFG_DATA_W-1:0] rel, input logic [FMT_W-1:0] fmt,
                                input logic [GAIN_W-1:0] gb, input logic [GAIN_W-1:0] gm,
                                input logic [GAIN_W-1:0] gh, input logic [GAIN_W-1:0] gl);
    write_reg(tbea_pkg::REG_BASS_COEF, bass);
    write_reg(tbea_pkg::REG_HIGH_COEF, high);
    write_reg(tbea_pkg::REG_RELEASE_COEF, rel);
    write_reg(tbea_pkg::REG_SAMPLE_FMT, CFG_DATA_W'(fmt));
    write_reg(tbea_pkg::REG_GAIN_BASS, CFG_DATA_W'(gb));
    write_reg(tbea_pkg::REG_GAIN_MID, CFG_DATA_W'(gm));
    write_reg(tbea_pkg::REG_GAIN_HIGH, CFG_DATA_W'(gh));
    write_reg(tbea_pkg::REG_GAIN_LEVEL, CFG_DATA_W'(gl));
    settings_count++;
  endtask

  // Wait for every frame and level result, then let a frame without a result finish.
  task automatic wait_drained();
    while (frames_pending.size() != 0 || in_valid_i || levels_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    shadow_regs[tbea_pkg::REG_BASS_COEF]    = CFG_DATA_W'(tbea_pkg::RST_BASS_COEF);
    shadow_regs[tbea_pkg::REG_HIGH_COEF]    = CFG_DATA_W'(tbea_pkg::RST_HIGH_COEF);
    shadow_regs[tbea_pkg::REG_RELEASE_COEF] = CFG_DATA_W'(tbea_pkg::RST_RELEASE_COEF);
    shadow_regs[tbea_pkg::REG_SAMPLE_FMT]   = CFG_DATA_W'(tbea_pkg::RST_SAMPLE_FMT);
    shadow_regs[tbea_pkg::REG_GAIN_BASS]    = CFG_DATA_W'(tbea_pkg::RST_GAIN_BASS);
    shadow_regs[tbea_pkg::REG_GAIN_MID]     = CFG_DATA_W'(tbea_pkg::RST_GAIN_MID);
    shadow_regs[tbea_pkg::REG_GAIN_HIGH]    = CFG_DATA_W'(tbea_pkg::RST_GAIN_HIGH);
    shadow_regs[tbea_pkg::REG_GAIN_LEVEL]   = CFG_DATA_W'(tbea_pkg::RST_GAIN_LEVEL);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings, 16-bit stereo: full-scale and opposite-sign frames.
    queue_frame(16'h7FFF, 16'h7FFF, 1'b0);
    queue_frame(16'h7FFF, 16'h7FFF, 1'b1);
    queue_frame(16'h8000, 16'h8000, 1'b1);
    queue_frame(16'h7FFF, 16'h8000, 1'b1);
    queue_frame(16'h8000, 16'h7FFF, 1'b0);
    queue_frame(16'h0000, 16'h0000, 1'b1);
    queue_frame(16'hFFFF, 16'h0001, 1'b1);
    queue_frame(16'h8000, 16'h8000, 1'b0);
    queue_frame(16'h0000, 16'h0000, 1'b1);
    queue_random_blocks(160);
    wait_drained();

    // 16-bit mono with the widest gains and edge coefficients; no idling on either side.
    send_skip_pct = 0;
    take_skip_pct = 0;
    apply_settings(25'd16777216, 25'd0, 25'd0, tbea_pkg::FMT_WIDE,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(16'h7FFF, 16'($urandom), 1'b1);
    queue_frame(16'h8000, 16'h1234, 1'b1);
    queue_frame(16'h0000, 16'hFFFF, 1'b1);
    queue_frame(16'h8000, 16'h7FFF, 1'b1);
    queue_random_blocks(120);
    wait_drained();
    send_skip_pct = 37;
    take_skip_pct = 37;

    // 8-bit mono: the high byte is ignored; instant release, zero gains.
    apply_settings(25'($urandom_range(0, 16777216)), 25'($urandom_range(0, 16777216)),
                   25'd16777216, 2'b00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(16'h00FF, 16'h0000, 1'b1);
    queue_frame(16'hFF00, 16'hFFFF, 1'b1);
    queue_frame(16'hA580, 16'h1234, 1'b1);
    queue_random_blocks(60);
    wait_drained();
    apply_settings(25'd358552, 25'd7171047, 25'd2013, 2'b00,
                   16'hFFFF, 16'd4096, 16'd1, 16'hFFFF);
    queue_random_blocks(60);
    wait_drained();

    // 8-bit stereo with coefficients above one, so the filters and envelopes saturate.
    apply_settings(25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, tbea_pkg::FMT_STEREO,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(16'hFFFF, 16'hFFFF, 1'b1);
    queue_frame(16'h0000, 16'h0000, 1'b1);
    queue_frame(16'hFF80, 16'h0080, 1'b1);
    queue_random_blocks(120);
    wait_drained();

    // Random settings, 16-bit stereo; the receiver holds off while frames keep coming.
    apply_settings(25'($urandom_range(0, 16777216)), 25'($urandom_range(0, 16777216)),
                   25'($urandom_range(0, 16777216)), tbea_pkg::FMT_WIDE | tbea_pkg::FMT_STEREO,
                   16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    for (int k = 0; k < 30; k++) queue_frame(pick_sample(), pick_sample(), 1'b1);
    backpressure_on = 1'b1;
    queue_random_blocks(150);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (levels_due.size() != 0) begin
      $display("%0t: %0d level results expected but never seen", $time, levels_due.size());
      fail_count++;
    end
    $display("Ran %0d frames through %0d register settings; %0d level results compared.",
             frames_accepted, settings_count, results_checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
